### hdl/ldq_pkg.sv
// Shared constants, codes and types for the linked deque with cursor.
// No dependencies; used by ldq_free, linked_deque_with_cursor and the testbench.
`default_nettype none
package ldq_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int PTR_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;

    // node pointer value that marks the end of the list
    localparam logic [PTR_W-1:0] END_MARK = PTR_W'(CAPACITY);

    // operation codes
    localparam logic [3:0] OP_PUSH_FRONT = 4'd0;
    localparam logic [3:0] OP_PUSH_BACK  = 4'd1;
    localparam logic [3:0] OP_POP_FRONT  = 4'd2;
    localparam logic [3:0] OP_POP_BACK   = 4'd3;
    localparam logic [3:0] OP_PEEK_FRONT = 4'd4;
    localparam logic [3:0] OP_PEEK_BACK  = 4'd5;
    localparam logic [3:0] OP_CUR_FIRST  = 4'd6;
    localparam logic [3:0] OP_CUR_NEXT   = 4'd7;
    localparam logic [3:0] OP_INSERT     = 4'd8;
    localparam logic [3:0] OP_DELETE     = 4'd9;
    localparam logic [3:0] OP_FIND       = 4'd10;
    localparam logic [3:0] OP_CLEAR      = 4'd11;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_AT_END = 2'd3;

    // control from the sequencer to the free pool
    typedef struct packed {
        logic take;
        logic give;
        logic clear;
    } free_ctl_t;

endpackage
`default_nettype wire

### hdl/ldq_ram.sv
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
`default_nettype none
module ldq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### hdl/ldq_free.sv
// Node allocator: a stack of recycled nodes plus a high-water mark of
// never-used nodes. Depends on ldq_pkg and ldq_ram.
`default_nettype none
module ldq_free (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire ldq_pkg::free_ctl_t       ctl,
    input  wire logic [ldq_pkg::IDX_W-1:0] give_idx,
    output logic      [ldq_pkg::IDX_W-1:0] alloc_idx
);
    import ldq_pkg::*;

    logic [PTR_W-1:0] rc_reg, rc_next;   // recycled words on the stack
    logic [PTR_W-1:0] hw_reg, hw_next;   // nodes handed out at least once
    logic [IDX_W-1:0] stk_q;
    logic [IDX_W-1:0] rd_addr;

    // top of stack is read every cycle; stable while the sequencer decides
    assign rd_addr   = IDX_W'(rc_reg - PTR_W'(1));
    assign alloc_idx = (rc_reg != '0) ? stk_q : hw_reg[IDX_W-1:0];

    ldq_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_stack (
        .clk   (clk),
        .we    (ctl.give),
        .waddr (rc_reg[IDX_W-1:0]),
        .wdata (give_idx),
        .raddr (rd_addr),
        .rdata (stk_q)
    );

    always_comb
    begin
        rc_next = rc_reg;
        hw_next = hw_reg;
        priority if (ctl.clear)
        begin
            rc_next = '0;
            hw_next = '0;
        end
        else if (ctl.give)
        begin
            rc_next = rc_reg + PTR_W'(1);
        end
        else if (ctl.take)
        begin
            if (rc_reg != '0)
                rc_next = rc_reg - PTR_W'(1);
            else
                hw_next = hw_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rc_reg <= '0;
            hw_reg <= '0;
        end
        else
        begin
            rc_reg <= rc_next;
            hw_reg <= hw_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (rc_reg <= hw_reg) && (hw_reg <= PTR_W'(CAPACITY)))
        else $error("free pool counts out of range");
    a_no_give_take: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.give && ctl.take))
        else $error("node taken and given in one cycle");
    a_give_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.give && !ctl.clear) |=> (rc_reg == $past(rc_reg) + PTR_W'(1)))
        else $error("recycle did not push the stack");
`endif
endmodule
`default_nettype wire

### hdl/linked_deque_with_cursor.sv
// Linked deque with cursor: sequencer, list head/tail/cursor registers and
// node memories. Depends on ldq_pkg, ldq_ram and ldq_free.
//
// Usage: drive mode and data_value and raise start while busy is low; the
// word is taken at that edge and busy rises. When the operation ends busy
// falls and done pulses for one cycle with value, status, found,
// cursor_at_end and element_count; the receiver cannot stall and must take
// the result in that cycle. A new start may be issued in the done cycle.
// Steps after accept: peek, pop, cursor first, clear and the status-only
// cases finish in S_EXEC; push and insert pass S_EXEC then S_LINK; cursor
// next and delete pass S_EXEC then S_CVAL; find stays in S_FIND, one node
// per step, until the match, the end of the list or the visit bound.
// Every link hop or neighbor update needs a registered read of the node
// memories followed by a write. One operation is in flight at a time.
// Reset empties the deque and puts the cursor at the end; no clearing pass
// is needed since nodes are handed out by a high-water mark.
`default_nettype none
module linked_deque_with_cursor (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [3:0]                  mode,
    input  wire logic signed [31:0]          data_value,
    output logic                             done,
    output logic signed [31:0]               value,
    output logic [1:0]                       status,
    output logic                             found,
    output logic                             cursor_at_end,
    output logic [6:0]                       element_count
);
    import ldq_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_LINK = 5'b00100,
        S_FIND = 5'b01000,
        S_CVAL = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [3:0]       mode_reg, mode_next;
    logic [VAL_W-1:0] dv_reg, dv_next;
    logic [PTR_W-1:0] first_reg, first_next;
    logic [PTR_W-1:0] last_reg, last_next;
    logic [PTR_W-1:0] cur_reg, cur_next;
    logic [PTR_W-1:0] cnt_reg, cnt_next;
    logic [PTR_W-1:0] tgt_reg, tgt_next;     // node addressed by the read
    logic [PTR_W-1:0] nb_reg, nb_next;       // neighbor before new node
    logic [PTR_W-1:0] na_reg, na_next;       // neighbor after new node
    logic [IDX_W-1:0] nn_reg, nn_next;       // new node
    logic [PTR_W-1:0] steps_reg, steps_next;
    logic             done_reg, done_next;
    logic [VAL_W-1:0] value_reg, value_next;
    logic [1:0]       status_reg, status_next;
    logic             found_reg, found_next;

    // memory ports
    logic [IDX_W-1:0] rd_addr;
    logic [VAL_W-1:0] val_q;
    logic [PTR_W-1:0] nxt_q, prv_q;
    logic             val_we, nxt_we, prv_we;
    logic [IDX_W-1:0] val_wa, nxt_wa, prv_wa;
    logic [PTR_W-1:0] nxt_wd, prv_wd;
    logic [PTR_W-1:0] rd_ptr;

    free_ctl_t        fctl;
    logic [IDX_W-1:0] alloc_idx;

    logic full, empty;

    assign full  = (cnt_reg == PTR_W'(CAPACITY));
    assign empty = (cnt_reg == '0);
    assign rd_addr = rd_ptr[IDX_W-1:0];

    ldq_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_val (
        .clk(clk), .we(val_we), .waddr(val_wa), .wdata(dv_reg),
        .raddr(rd_addr), .rdata(val_q));
    ldq_ram #(.WIDTH(PTR_W), .DEPTH(CAPACITY)) u_nxt (
        .clk(clk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd),
        .raddr(rd_addr), .rdata(nxt_q));
    ldq_ram #(.WIDTH(PTR_W), .DEPTH(CAPACITY)) u_prv (
        .clk(clk), .we(prv_we), .waddr(prv_wa), .wdata(prv_wd),
        .raddr(rd_addr), .rdata(prv_q));

    ldq_free u_free (
        .clk(clk), .rst_n(rst_n), .ctl(fctl),
        .give_idx(tgt_reg[IDX_W-1:0]), .alloc_idx(alloc_idx));

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        dv_next    = dv_reg;
        first_next = first_reg;
        last_next  = last_reg;
        cur_next   = cur_reg;
        cnt_next   = cnt_reg;
        tgt_next   = tgt_reg;
        nb_next    = nb_reg;
        na_next    = na_reg;
        nn_next    = nn_reg;
        steps_next = steps_reg;
        done_next  = 1'b0;
        value_next = value_reg;
        status_next = status_reg;
        found_next = found_reg;
        rd_ptr     = tgt_reg;
        val_we = 1'b0; nxt_we = 1'b0; prv_we = 1'b0;
        val_wa = nn_reg; nxt_wa = nn_reg; prv_wa = nn_reg;
        nxt_wd = na_reg; prv_wd = nb_reg;
        fctl = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mode_next   = mode;
                    dv_next     = data_value;
                    value_next  = '0;
                    status_next = ST_OK;
                    found_next  = 1'b0;
                    steps_next  = '0;
                    unique case (mode)
                        OP_POP_BACK, OP_PEEK_BACK: rd_ptr = last_reg;
                        OP_CUR_NEXT, OP_INSERT, OP_DELETE: rd_ptr = cur_reg;
                        default: rd_ptr = first_reg;
                    endcase
                    tgt_next   = rd_ptr;
                    state_next = (mode == OP_FIND) ? S_FIND : S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                unique case (mode_reg)
                    OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT:
                    begin
                        if (mode_reg == OP_INSERT)
                            value_next = (cur_reg == END_MARK) ? '0 : val_q;
                        if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            unique case (mode_reg)
                                OP_PUSH_FRONT:
                                begin
                                    nb_next = END_MARK;
                                    na_next = first_reg;
                                end
                                OP_PUSH_BACK:
                                begin
                                    nb_next = last_reg;
                                    na_next = END_MARK;
                                end
                                default:
                                begin
                                    nb_next = (cur_reg == END_MARK) ? last_reg : prv_q;
                                    na_next = cur_reg;
                                end
                            endcase
                            nn_next = alloc_idx;
                            fctl.take = 1'b1;
                            // new node fields
                            val_we = 1'b1; nxt_we = 1'b1; prv_we = 1'b1;
                            val_wa = alloc_idx; nxt_wa = alloc_idx; prv_wa = alloc_idx;
                            nxt_wd = na_next; prv_wd = nb_next;
                            if (mode_reg == OP_INSERT)
                            begin
                                cur_next   = {1'b0, alloc_idx};
                                value_next = dv_reg;
                            end
                            done_next  = 1'b0;
                            state_next = S_LINK;
                        end
                    end

                    OP_POP_FRONT, OP_POP_BACK, OP_DELETE:
                    begin
                        if (mode_reg == OP_DELETE && cur_reg == END_MARK)
                        begin
                            status_next = ST_AT_END;
                        end
                        else if (mode_reg != OP_DELETE && empty)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            // unlink the node just read
                            if (prv_q == END_MARK)
                                first_next = nxt_q;
                            else
                            begin
                                nxt_we = 1'b1;
                                nxt_wa = prv_q[IDX_W-1:0];
                                nxt_wd = nxt_q;
                            end
                            if (nxt_q == END_MARK)
                                last_next = prv_q;
                            else
                            begin
                                prv_we = 1'b1;
                                prv_wa = nxt_q[IDX_W-1:0];
                                prv_wd = prv_q;
                            end
                            if (cur_reg == tgt_reg)
                                cur_next = nxt_q;
                            fctl.give = 1'b1;
                            cnt_next  = cnt_reg - PTR_W'(1);
                            if (mode_reg == OP_DELETE)
                            begin
                                rd_ptr     = nxt_q;
                                done_next  = 1'b0;
                                state_next = S_CVAL;
                            end
                            else
                            begin
                                value_next = val_q;
                            end
                        end
                    end

                    OP_PEEK_FRONT, OP_PEEK_BACK:
                    begin
                        if (empty)
                            status_next = ST_EMPTY;
                        else
                            value_next = val_q;
                    end

                    OP_CUR_FIRST:
                    begin
                        cur_next   = first_reg;
                        value_next = (first_reg == END_MARK) ? '0 : val_q;
                    end

                    OP_CUR_NEXT:
                    begin
                        if (cur_reg == END_MARK)
                        begin
                            status_next = ST_AT_END;
                        end
                        else
                        begin
                            cur_next   = nxt_q;
                            rd_ptr     = nxt_q;
                            done_next  = 1'b0;
                            state_next = S_CVAL;
                        end
                    end

                    OP_CLEAR:
                    begin
                        fctl.clear = 1'b1;
                        first_next = END_MARK;
                        last_next  = END_MARK;
                        cur_next   = END_MARK;
                        cnt_next   = '0;
                    end

                    default:
                    begin
                    end
                endcase
            end

            // hook the new node into its neighbors
            S_LINK:
            begin
                if (nb_reg == END_MARK)
                    first_next = {1'b0, nn_reg};
                else
                begin
                    nxt_we = 1'b1;
                    nxt_wa = nb_reg[IDX_W-1:0];
                    nxt_wd = {1'b0, nn_reg};
                end
                if (na_reg == END_MARK)
                    last_next = {1'b0, nn_reg};
                else
                begin
                    prv_we = 1'b1;
                    prv_wa = na_reg[IDX_W-1:0];
                    prv_wd = {1'b0, nn_reg};
                end
                cnt_next   = cnt_reg + PTR_W'(1);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            // one node per cycle; data of tgt_reg arrives now
            S_FIND:
            begin
                if (tgt_reg == END_MARK || steps_reg == PTR_W'(CAPACITY))
                begin
                    cur_next   = END_MARK;
                    value_next = '0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (val_q == dv_reg)
                begin
                    cur_next   = tgt_reg;
                    found_next = 1'b1;
                    value_next = val_q;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_ptr     = nxt_q;
                    tgt_next   = nxt_q;
                    steps_next = steps_reg + PTR_W'(1);
                end
            end

            // value under the new cursor
            S_CVAL:
            begin
                value_next = (cur_reg == END_MARK) ? '0 : val_q;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            first_reg <= END_MARK;
            last_reg  <= END_MARK;
            cur_reg   <= END_MARK;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= first_next;
            last_reg  <= last_next;
            cur_reg   <= cur_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        dv_reg     <= dv_next;
        tgt_reg    <= tgt_next;
        nb_reg     <= nb_next;
        na_reg     <= na_next;
        nn_reg     <= nn_next;
        steps_reg  <= steps_next;
        value_reg  <= value_next;
        status_reg <= status_next;
        found_reg  <= found_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign value         = value_reg;
    assign status        = status_reg;
    assign found         = found_reg;
    assign cursor_at_end = (cur_reg == END_MARK);
    assign element_count = 7'(cnt_reg);

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= PTR_W'(CAPACITY))
        else $error("element count above capacity");
    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (first_reg == END_MARK && last_reg == END_MARK))
        else $error("empty list with dangling head or tail");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(busy) && !busy))
        else $error("result strobe without a finished operation");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not start an operation");
`endif
endmodule
`default_nettype wire

### tb/tb_linked_deque_with_cursor.sv
// Testbench for linked_deque_with_cursor: random and directed deque operations
// checked against an in-bench list model. Depends on ldq_pkg and the block RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb_linked_deque_with_cursor;
    import ldq_pkg::*;

    typedef struct packed {
        logic [3:0]         op;
        logic signed [31:0] data;
    } cmd_word_t;

    typedef struct packed {
        logic signed [31:0] val;
        logic [1:0]         st;
        logic               hit;
        logic               at_end;
        logic [6:0]         count;
    } resp_word_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [3:0] mode;
    logic signed [31:0] data_value;
    logic done;
    logic signed [31:0] value;
    logic [1:0] status;
    logic found;
    logic cursor_at_end;
    logic [6:0] element_count;

    linked_deque_with_cursor u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .mode(mode), .data_value(data_value), .done(done),
        .value(value), .status(status), .found(found),
        .cursor_at_end(cursor_at_end), .element_count(element_count)
    );

    cmd_word_t  pending_cmds[$];
    resp_word_t expected_resps[$];
    int         send_idle_pct;
    bit         hold_send;
    int         errors;
    int         cycles;

    // deque mirror: position-ordered values plus cursor position (== size at end)
    logic signed [31:0] mirror[$];
    int                 cur_pos;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // apply one word to the mirror and return its result
    function automatic resp_word_t apply_cmd(cmd_word_t c);
        resp_word_t r;
        int i;
        r = '0;
        case (c.op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
                if (mirror.size() >= CAPACITY) r.st = ST_FULL;
                else if (c.op == OP_PUSH_FRONT)
                begin
                    mirror.push_front(c.data);
                    cur_pos++;
                end
                else
                begin
                    if (cur_pos == mirror.size()) cur_pos++;
                    mirror.push_back(c.data);
                end
            OP_POP_FRONT, OP_POP_BACK:
                if (mirror.size() == 0) r.st = ST_EMPTY;
                else if (c.op == OP_POP_FRONT)
                begin
                    r.val = mirror.pop_front();
                    if (cur_pos > 0) cur_pos--;
                end
                else
                begin
                    r.val = mirror.pop_back();
                    if (cur_pos > mirror.size()) cur_pos = mirror.size();
                end
            OP_PEEK_FRONT, OP_PEEK_BACK:
                if (mirror.size() == 0) r.st = ST_EMPTY;
                else r.val = (c.op == OP_PEEK_FRONT) ? mirror[0] : mirror[$];
            OP_CUR_FIRST:
                cur_pos = 0;
            OP_CUR_NEXT:
                if (cur_pos == mirror.size()) r.st = ST_AT_END;
                else cur_pos++;
            OP_INSERT:
                if (mirror.size() >= CAPACITY) r.st = ST_FULL;
                else mirror.insert(cur_pos, c.data);
            OP_DELETE:
                if (cur_pos == mirror.size()) r.st = ST_AT_END;
                else mirror.delete(cur_pos);
            OP_FIND:
            begin
                cur_pos = mirror.size();
                for (i = 0; i < mirror.size(); i++)
                    if (mirror[i] == c.data)
                    begin
                        cur_pos = i;
                        break;
                    end
                r.hit = (cur_pos != mirror.size());
            end
            OP_CLEAR:
            begin
                mirror.delete();
                cur_pos = 0;
            end
            default: ;
        endcase
        if (c.op inside {OP_CUR_FIRST, OP_CUR_NEXT, OP_INSERT, OP_DELETE, OP_FIND})
            r.val = (cur_pos < mirror.size()) ? mirror[cur_pos] : 32'sd0;
        r.at_end = (cur_pos == mirror.size());
        r.count  = 7'(mirror.size());
        return r;
    endfunction

    // driver: one word per accept, random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            mode       <= '0;
            data_value <= '0;
        end
        else if (!(start && busy))
        begin
            if (start) expected_resps.push_back(apply_cmd(cmd_word_t'({mode, data_value})));
            if (pending_cmds.size() > 0 && !hold_send &&
                $urandom_range(99) >= send_idle_pct)
            begin
                cmd_word_t c;
                c = pending_cmds.pop_front();
                start      <= 1'b1;
                mode       <= c.op;
                data_value <= c.data;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: compare each done word with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            resp_word_t e;
            if (expected_resps.size() == 0)
            begin
                $display("%0t: unexpected result value=%0d status=%0d", $time, value, status);
                errors++;
            end
            else
            begin
                e = expected_resps.pop_front();
                if (e.val !== value)
                begin
                    $display("%0t: value exp %0d got %0d", $time, e.val, value);
                    errors++;
                end
                if (e.st !== status)
                begin
                    $display("%0t: status exp %0d got %0d", $time, e.st, status);
                    errors++;
                end
                if (e.hit !== found)
                begin
                    $display("%0t: found exp %0d got %0d", $time, e.hit, found);
                    errors++;
                end
                if (e.at_end !== cursor_at_end)
                begin
                    $display("%0t: cursor_at_end exp %0d got %0d", $time, e.at_end,
                             cursor_at_end);
                    errors++;
                end
                if (e.count !== element_count)
                begin
                    $display("%0t: element_count exp %0d got %0d", $time, e.count,
                             element_count);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 400000)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // pick a data value, often one already stored so find hits
    function automatic logic signed [31:0] pick_data();
        int k;
        k = $urandom_range(9);
        if (k < 4) return $urandom_range(7);
        if (k == 4) return 32'sh7fffffff;
        if (k == 5) return 32'sh80000000;
        return $urandom;
    endfunction

    task automatic add_cmd(logic [3:0] op, logic signed [31:0] d);
        pending_cmds.push_back('{op, d});
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || start || expected_resps.size() > 0)
            @(posedge clk);
    endtask

    task automatic random_phase(int n, int fill_bias);
        int i;
        int k;
        for (i = 0; i < n; i++)
        begin
            k = $urandom_range(99);
            if (k < fill_bias) add_cmd($urandom_range(1) ? OP_PUSH_BACK : OP_INSERT,
                                       pick_data());
            else if (k < fill_bias + 5) add_cmd(OP_PUSH_FRONT, pick_data());
            else if (k < 97) add_cmd(4'($urandom_range(15)), pick_data());
            else add_cmd(OP_CLEAR, 0);
        end
    endtask

    initial
    begin
        int i;
        int p;
        rst_n = 1'b0;
        hold_send = 1'b0;
        send_idle_pct = 0;
        errors = 0;
        cycles = 0;
        cur_pos = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty cases, extremes, every op
        add_cmd(OP_POP_FRONT, 0);
        add_cmd(OP_PEEK_BACK, 0);
        add_cmd(OP_CUR_FIRST, 0);
        add_cmd(OP_CUR_NEXT, 0);
        add_cmd(OP_DELETE, 0);
        add_cmd(OP_FIND, 5);
        add_cmd(OP_INSERT, 32'sh7fffffff);
        add_cmd(OP_PUSH_FRONT, 32'sh80000000);
        add_cmd(OP_PUSH_BACK, -1);
        add_cmd(OP_PEEK_FRONT, 0);
        add_cmd(OP_PEEK_BACK, 0);
        add_cmd(OP_CUR_FIRST, 0);
        add_cmd(OP_CUR_NEXT, 0);
        add_cmd(OP_INSERT, 3);
        add_cmd(OP_POP_FRONT, 0);
        add_cmd(OP_FIND, 3);
        add_cmd(OP_POP_FRONT, 0);
        add_cmd(OP_DELETE, 0);
        add_cmd(OP_FIND, 12345);
        add_cmd(OP_POP_BACK, 0);
        add_cmd(4'd12, 0);
        add_cmd(4'd15, 32'sh55aa55aa);
        add_cmd(OP_CLEAR, 0);
        wait_drained();

        // fill to full and past it, then drain past empty
        for (i = 0; i < CAPACITY + 2; i++) add_cmd(OP_PUSH_BACK, $urandom);
        add_cmd(OP_INSERT, 1);
        add_cmd(OP_FIND, 32'sh7fffffff);
        for (i = 0; i < CAPACITY + 2; i++) add_cmd(OP_POP_FRONT, 0);

        // random phases with differing sender idling
        for (p = 0; p < 4; p++)
        begin
            wait_drained();
            send_idle_pct = (p == 1) ? 82 : (p == 3) ? 9 : 0;
            random_phase(250, (p == 2) ? 45 : 30);
            if (p == 0)
            begin
                // hold sending until every result is back
                repeat (60) @(posedge clk);
                hold_send = 1'b1;
                while (expected_resps.size() > 0 || start) @(posedge clk);
                hold_send = 1'b0;
            end
        end
        wait_drained();
        repeat (CAPACITY + 20) @(posedge clk);

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire

### linked_deque_with_cursor.f
hdl/ldq_pkg.sv
hdl/ldq_ram.sv
hdl/ldq_free.sv
hdl/linked_deque_with_cursor.sv
tb/tb_linked_deque_with_cursor.sv
